// ===== rtl/pan_tilt_pixel_error_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// pan/tilt tracker assertion macros
// shared assertion forms for the tracker checker
// ----------------------------------------------------------------------------
`ifndef PAN_TILT_PIXEL_ERROR_TRACKER_MACROS_SVH
`define PAN_TILT_PIXEL_ERROR_TRACKER_MACROS_SVH

// same-cycle implication, held off during reset
`define PTPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker assertion failed");

// next-cycle implication, held off during reset
`define PTPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`endif

// ===== rtl/ptpe_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpe_pkg
// types, constants and angle step tables of the pan/tilt tracker
// ----------------------------------------------------------------------------
package ptpe_pkg;

    // frame geometry and angle format
    localparam int HALF_WIDTH      = 160;
    localparam int HALF_HEIGHT     = 120;
    localparam int ANGLE_FRAC_BITS = 6;

    // field widths
    localparam int PIX_W  = 16;
    localparam int CX_W   = 9;
    localparam int CY_W   = 8;
    localparam int DZP_W  = 8;
    localparam int DZT_W  = 7;
    localparam int PAN_W  = 15;
    localparam int TILT_W = 14;
    localparam int STAT_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PAN_W;

    // error magnitude and table sizing
    localparam int HALF_MAX     = (HALF_WIDTH > HALF_HEIGHT) ? HALF_WIDTH : HALF_HEIGHT;
    localparam int MAG_W        = $clog2(HALF_MAX + 1);
    localparam int PAN_TAB_N    = HALF_WIDTH + 1;
    localparam int TILT_TAB_N   = HALF_HEIGHT + 1;
    localparam int PAN_IDX_W    = $clog2(PAN_TAB_N);
    localparam int TILT_IDX_W   = $clog2(TILT_TAB_N);
    // largest half field of view is under 22 degrees
    localparam int STEP_MAX_DEG = 22;
    localparam int STEP_W       = $clog2((STEP_MAX_DEG << ANGLE_FRAC_BITS) + 1);

    // tan of half field of view, Q16
    localparam longint TAN_HALF_HFOV_Q16 = 26212;
    localparam longint TAN_HALF_VFOV_Q16 = 13095;
    localparam int     CORDIC_STEPS      = 16;

    localparam logic [PIX_W-1:0] STOP_CODE = '1;

    // reset values
    localparam logic [CX_W-1:0]   CENTER_X_RST = CX_W'(160);
    localparam logic [CY_W-1:0]   CENTER_Y_RST = CY_W'(120);
    localparam logic [DZP_W-1:0]  DZ_PAN_RST   = DZP_W'(5);
    localparam logic [DZT_W-1:0]  DZ_TILT_RST  = DZT_W'(5);
    localparam logic [PAN_W-1:0]  PAN_MIN_RST  = '0;
    localparam logic [PAN_W-1:0]  PAN_MAX_RST  = PAN_W'(270 << ANGLE_FRAC_BITS);
    localparam logic [TILT_W-1:0] TILT_LO_RST  = TILT_W'(10 << ANGLE_FRAC_BITS);
    localparam logic [TILT_W-1:0] TILT_HI_RST  = TILT_W'(170 << ANGLE_FRAC_BITS);
    localparam logic [PAN_W-1:0]  HELD_PAN_RST  = PAN_W'(135 << ANGLE_FRAC_BITS);
    localparam logic [TILT_W-1:0] HELD_TILT_RST = TILT_W'(85 << ANGLE_FRAC_BITS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DZ_PAN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DZ_TILT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_HI   = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_UPDATED = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_STOP    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_DEAD    = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pos_x;
        logic [PIX_W-1:0] pos_y;
    } track_t;

    typedef struct packed {
        logic [PAN_W-1:0]  pan_angle;
        logic [TILT_W-1:0] tilt_angle;
        logic [STAT_W-1:0] status;
    } cmd_t;

    // pixel error: sign and saturated magnitude, zero inside the dead zone
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } err_t;

    typedef logic [STEP_W-1:0] pan_tab_t [PAN_TAB_N];
    typedef logic [STEP_W-1:0] tilt_tab_t [TILT_TAB_N];

    // atan(2^-i) in 1/65536 degree
    localparam longint ATAN_STEP [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    // vectoring cordic for atan(mag/half * tan), rounded to the angle lsb
    function automatic longint angle_mag(input longint mag, input longint half,
                                         input longint tan_q16);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = half * 65536;
        y = mag * tan_q16;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = (y >= 0) ? (y >>> i) : -((-y) >>> i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        if (z < 0)
        begin
            z = 0;
        end
        z = (z + (longint'(1) << (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
        return z;
    endfunction

    function automatic pan_tab_t build_pan_tab();
        pan_tab_t tab;
        for (int m = 0; m < PAN_TAB_N; m++)
        begin
            tab[m] = (m == 0) ? '0
                   : STEP_W'(angle_mag(longint'(m), HALF_WIDTH, TAN_HALF_HFOV_Q16));
        end
        return tab;
    endfunction

    function automatic tilt_tab_t build_tilt_tab();
        tilt_tab_t tab;
        for (int m = 0; m < TILT_TAB_N; m++)
        begin
            tab[m] = (m == 0) ? '0
                   : STEP_W'(angle_mag(longint'(m), HALF_HEIGHT, TAN_HALF_VFOV_Q16));
        end
        return tab;
    endfunction

    localparam pan_tab_t  PAN_STEP_TAB  = build_pan_tab();
    localparam tilt_tab_t TILT_STEP_TAB = build_tilt_tab();

endpackage

// ===== rtl/ptpe_err.sv =====
// ----------------------------------------------------------------------------
// ptpe_err
// pixel error of one axis: offset from centre, saturation and dead zone
// ----------------------------------------------------------------------------
module ptpe_err (
    input  logic [ptpe_pkg::PIX_W-1:0] pos,
    input  logic [ptpe_pkg::CX_W-1:0]  center,
    input  logic [ptpe_pkg::DZP_W-1:0] dz_lim,
    input  logic [ptpe_pkg::MAG_W-1:0] half,
    output ptpe_pkg::err_t             err
);
    import ptpe_pkg::*;

    logic             below;
    logic [PIX_W-1:0] diff;
    logic [MAG_W-1:0] mag_sat;

    assign below = pos < PIX_W'(center);
    assign diff  = below ? (PIX_W'(center) - pos) : (pos - PIX_W'(center));

    // saturate to the half frame
    assign mag_sat = (diff > PIX_W'(half)) ? half : diff[MAG_W-1:0];

    always_comb
    begin
        err.neg = below;
        err.mag = (DZP_W'(mag_sat) <= dz_lim) ? '0 : mag_sat;
    end

endmodule

// ===== rtl/ptpe_clamp.sv =====
// ----------------------------------------------------------------------------
// ptpe_clamp
// adds an angle step to or subtracts it from the held angle, then clamps to the axis limits
// ----------------------------------------------------------------------------
module ptpe_clamp (
    input  logic [ptpe_pkg::PAN_W-1:0]  held,
    input  logic [ptpe_pkg::STEP_W-1:0] step,
    input  logic                        up,
    input  logic [ptpe_pkg::PAN_W-1:0]  lo,
    input  logic [ptpe_pkg::PAN_W-1:0]  hi,
    output logic [ptpe_pkg::PAN_W-1:0]  angle
);
    import ptpe_pkg::*;

    localparam int SUM_W = PAN_W + 2;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;

    assign lo_s = signed'(SUM_W'(lo));
    assign hi_s = signed'(SUM_W'(hi));
    assign sum  = up ? (signed'(SUM_W'(held)) + signed'(SUM_W'(step)))
                     : (signed'(SUM_W'(held)) - signed'(SUM_W'(step)));

    // min is checked first: with crossed limits a sum below min gives min, any other gives max
    always_comb
    begin
        if (sum < lo_s)
        begin
            angle = lo;
        end
        else if (sum > hi_s)
        begin
            angle = hi;
        end
        else
        begin
            angle = sum[PAN_W-1:0];
        end
    end

endmodule

// ===== rtl/pan_tilt_pixel_error_tracker.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_pixel_error_tracker
// turns target pixel positions into clamped pan and tilt servo angles
// ----------------------------------------------------------------------------
// Each transfer on the track channel carries a target pixel position and
// yields exactly one transfer on the cmd channel with the held pan and tilt
// angles (1/64 degree) and a status: updated, stop (position 65535,65535) or
// dead zone (both errors inside their dead zones). The block takes one item
// per cycle while the cmd side is ready; an item passes through the input
// register and then the result register. The rate is set by the held
// angle loop: error, step table lookup, add and clamp are all combinational
// so the next item sees the updated angle. The result register holds a
// finished result while the input register takes the next item. Register
// writes are expected only while the block is empty.
// ----------------------------------------------------------------------------
module pan_tilt_pixel_error_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    // target positions
    input  logic                            track_valid,
    output logic                            track_ready,
    input  ptpe_pkg::track_t                track,
    // servo commands
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output ptpe_pkg::cmd_t                  cmd,
    // register writes
    input  logic                            cfg_wr_en,
    input  logic [ptpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptpe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ptpe_pkg::*;

    // configuration registers
    logic [CX_W-1:0]   center_x_reg;
    logic [CY_W-1:0]   center_y_reg;
    logic [DZP_W-1:0]  dz_pan_reg;
    logic [DZT_W-1:0]  dz_tilt_reg;
    logic [PAN_W-1:0]  pan_min_reg;
    logic [PAN_W-1:0]  pan_max_reg;
    logic [TILT_W-1:0] tilt_lo_reg;
    logic [TILT_W-1:0] tilt_hi_reg;

    // held servo angles
    logic [PAN_W-1:0]  held_pan_reg;
    logic [TILT_W-1:0] held_tilt_reg;
    logic [PAN_W-1:0]  held_pan_next;
    logic [TILT_W-1:0] held_tilt_next;

    // input register
    logic   in_valid_reg;
    track_t in_data_reg;

    // result register
    logic cmd_valid_reg;
    cmd_t cmd_data_reg;
    cmd_t cmd_data_next;

    logic advance;
    logic take_in;
    logic is_stop;
    logic is_dead;
    logic update;

    err_t              err_x;
    err_t              err_y;
    logic [STEP_W-1:0] step_pan;
    logic [STEP_W-1:0] step_tilt;
    logic [PAN_W-1:0]  pan_clamped;
    logic [PAN_W-1:0]  tilt_clamped;

    // ------------------------------------------------------------------------
    // handshake: result register frees when empty or taken downstream,
    // the input register moves into it whenever it frees
    // ------------------------------------------------------------------------
    assign advance     = !cmd_valid_reg || cmd_ready;
    assign track_ready = !in_valid_reg || advance;
    assign take_in     = track_valid && track_ready;

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_data_reg;

    // ------------------------------------------------------------------------
    // register writes
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            dz_pan_reg   <= DZ_PAN_RST;
            dz_tilt_reg  <= DZ_TILT_RST;
            pan_min_reg  <= PAN_MIN_RST;
            pan_max_reg  <= PAN_MAX_RST;
            tilt_lo_reg  <= TILT_LO_RST;
            tilt_hi_reg  <= TILT_HI_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data[CX_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[CY_W-1:0];
                REG_DZ_PAN:   dz_pan_reg   <= cfg_data[DZP_W-1:0];
                REG_DZ_TILT:  dz_tilt_reg  <= cfg_data[DZT_W-1:0];
                REG_PAN_MIN:  pan_min_reg  <= cfg_data[PAN_W-1:0];
                REG_PAN_MAX:  pan_max_reg  <= cfg_data[PAN_W-1:0];
                REG_TILT_LO:  tilt_lo_reg  <= cfg_data[TILT_W-1:0];
                REG_TILT_HI:  tilt_hi_reg  <= cfg_data[TILT_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pixel errors, one unit per axis
    // ------------------------------------------------------------------------
    ptpe_err u_err_x (
        .pos    (in_data_reg.pos_x),
        .center (center_x_reg),
        .dz_lim (dz_pan_reg),
        .half   (MAG_W'(HALF_WIDTH)),
        .err    (err_x)
    );

    ptpe_err u_err_y (
        .pos    (in_data_reg.pos_y),
        .center (CX_W'(center_y_reg)),
        .dz_lim (DZP_W'(dz_tilt_reg)),
        .half   (MAG_W'(HALF_HEIGHT)),
        .err    (err_y)
    );

    // stop needs both coordinates at the code; one alone is a far position
    assign is_stop = (in_data_reg.pos_x == STOP_CODE) &&
                     (in_data_reg.pos_y == STOP_CODE);
    assign is_dead = (err_x.mag == '0) && (err_y.mag == '0);
    assign update  = !is_stop && !is_dead;

    // angle step magnitudes from the field-of-view tables; zero error gives zero
    assign step_pan  = PAN_STEP_TAB[err_x.mag[PAN_IDX_W-1:0]];
    assign step_tilt = TILT_STEP_TAB[err_y.mag[TILT_IDX_W-1:0]];

    // target right of or below centre turns the servo down, hence the sign flip
    ptpe_clamp u_clamp_pan (
        .held  (held_pan_reg),
        .step  (step_pan),
        .up    (err_x.neg),
        .lo    (pan_min_reg),
        .hi    (pan_max_reg),
        .angle (pan_clamped)
    );

    ptpe_clamp u_clamp_tilt (
        .held  (PAN_W'(held_tilt_reg)),
        .step  (step_tilt),
        .up    (err_y.neg),
        .lo    (PAN_W'(tilt_lo_reg)),
        .hi    (PAN_W'(tilt_hi_reg)),
        .angle (tilt_clamped)
    );

    // even a zero-step axis is clamped when the other one moves
    always_comb
    begin
        held_pan_next  = update ? pan_clamped : held_pan_reg;
        held_tilt_next = update ? tilt_clamped[TILT_W-1:0] : held_tilt_reg;

        cmd_data_next.pan_angle  = held_pan_next;
        cmd_data_next.tilt_angle = held_tilt_next;
        if (is_stop)
        begin
            cmd_data_next.status = STATUS_STOP;
        end
        else if (is_dead)
        begin
            cmd_data_next.status = STATUS_DEAD;
        end
        else
        begin
            cmd_data_next.status = STATUS_UPDATED;
        end
    end

    // ------------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            cmd_valid_reg <= 1'b0;
            held_pan_reg  <= HELD_PAN_RST;
            held_tilt_reg <= HELD_TILT_RST;
        end
        else
        begin
            if (track_ready)
            begin
                in_valid_reg <= track_valid;
            end
            if (advance)
            begin
                cmd_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    held_pan_reg  <= held_pan_next;
                    held_tilt_reg <= held_tilt_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg <= track;
        end
        if (advance && in_valid_reg)
        begin
            cmd_data_reg <= cmd_data_next;
        end
    end

endmodule

// ===== rtl/ptpe_checker.sv =====
// ----------------------------------------------------------------------------
// ptpe_checker
// port-level checks of the pan/tilt tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "pan_tilt_pixel_error_tracker_macros.svh"

module ptpe_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             track_valid,
    input logic             track_ready,
    input ptpe_pkg::track_t track,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input ptpe_pkg::cmd_t   cmd
);
    import ptpe_pkg::*;

    logic  track_seen;
    logic  status_ok;
    assign track_seen = (track.pos_x == STOP_CODE) || 1'b1;
    assign status_ok  = (cmd.status == STATUS_UPDATED) || (cmd.status == STATUS_STOP) ||
                        (cmd.status == STATUS_DEAD);

    // only the three defined status codes leave the block
    `PTPE_ASSERT_NOW(a_status_code, clk, rst_n, cmd_valid && track_seen, status_ok)

    // an empty result side never blocks the input
    `PTPE_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !cmd_valid, track_ready)

    // an accepted item reaches the output through the input and result registers once the receiver is ready
    `PTPE_ASSERT_NEXT(a_latency, clk, rst_n, (track_valid && track_ready) ##1 cmd_ready, cmd_valid)

    // a stalled result holds
    `PTPE_ASSERT_NEXT(a_out_hold, clk, rst_n, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd))

endmodule

bind pan_tilt_pixel_error_tracker ptpe_checker u_ptpe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .track_valid (track_valid),
    .track_ready (track_ready),
    .track       (track),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pan/tilt pixel error tracker
// ----------------------------------------------------------------------------
// Drives target positions on the track channel and checks every command
// transfer against an in-bench model of the servo loop. The model has its
// own CORDIC atan, dead zone and clamp, and its own copy of the registers
// and held angles. Directed corner positions come first. Then limit corner
// settings run, then random register settings with mixed traffic. A long
// output hold closes the run. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    import ptpe_pkg::*;

    // cycles with no transfer at all before the run is called hung
    localparam int QUIET_LIMIT = 2000;
    // length of the deliberate output hold
    localparam int LONG_HOLD   = 200;

    // atan(2^-k) in 1/65536 degree, one entry per cordic iteration
    localparam longint ATAN_Q16 [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };
    // tan of half the horizontal and vertical field of view, Q16
    localparam longint PAN_TAN_Q16  = 26212;
    localparam longint TILT_TAN_Q16 = 13095;

    // one full set of register words, in cfg_data width
    typedef struct {
        logic [CFG_DATA_W-1:0] center_x;
        logic [CFG_DATA_W-1:0] center_y;
        logic [CFG_DATA_W-1:0] dz_pan;
        logic [CFG_DATA_W-1:0] dz_tilt;
        logic [CFG_DATA_W-1:0] pan_min;
        logic [CFG_DATA_W-1:0] pan_max;
        logic [CFG_DATA_W-1:0] tilt_lo;
        logic [CFG_DATA_W-1:0] tilt_hi;
    } tracker_regs_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  track_valid = 1'b0;
    logic                  track_ready;
    track_t                track = '0;
    logic                  cmd_valid;
    logic                  cmd_ready = 1'b0;
    cmd_t                  cmd;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // model copy of the registers and the held servo angles
    logic [CX_W-1:0]   ctr_x    = CENTER_X_RST;
    logic [CY_W-1:0]   ctr_y    = CENTER_Y_RST;
    logic [DZP_W-1:0]  dz_pan   = DZ_PAN_RST;
    logic [DZT_W-1:0]  dz_tilt  = DZ_TILT_RST;
    logic [PAN_W-1:0]  pan_lo   = PAN_MIN_RST;
    logic [PAN_W-1:0]  pan_hi   = PAN_MAX_RST;
    logic [TILT_W-1:0] tilt_lo  = TILT_LO_RST;
    logic [TILT_W-1:0] tilt_hi  = TILT_HI_RST;
    logic [PAN_W-1:0]  cur_pan  = HELD_PAN_RST;
    logic [TILT_W-1:0] cur_tilt = HELD_TILT_RST;

    // commands still owed by the block, oldest first
    cmd_t pending_cmds [$];
    cmd_t oldest_cmd;

    // idle shaping: per-transfer gaps are drawn from 0 to these maxima
    int gap_max   = 6;
    int stall_max = 6;
    // a nonzero value makes the receiver hold off that many cycles once
    int hold_off_request = 0;

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_moved = 0;
    int n_dead = 0;
    int n_stop = 0;
    int n_settings = 0;
    int n_long_holds = 0;

    pan_tilt_pixel_error_tracker u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .track_valid (track_valid),
        .track_ready (track_ready),
        .track       (track),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // servo loop model
    // ------------------------------------------------------------------------

    // vectoring cordic: angle of (run, rise) in 1/65536 degree
    function automatic longint cordic_atan(input longint run, input longint rise);
        longint vx;
        longint vy;
        longint acc;
        longint dx;
        longint dy;
        vx  = run;
        vy  = rise;
        acc = 0;
        for (int k = 0; k < 16; k++)
        begin
            dx = vx >>> k;
            // rise shifts truncate toward zero
            dy = (vy < 0) ? -((-vy) >>> k) : (vy >>> k);
            if (vy >= 0)
            begin
                vx  = vx + dy;
                vy  = vy - dx;
                acc = acc + ATAN_Q16[k];
            end
            else
            begin
                vx  = vx - dy;
                vy  = vy + dx;
                acc = acc - ATAN_Q16[k];
            end
        end
        return acc;
    endfunction

    // servo step for one pixel error, opposite in sign to the error
    function automatic int servo_step(input int err, input int half, input longint tan_q16);
        longint deg_q16;
        int     lsbs;
        if (err == 0)
        begin
            return 0;
        end
        deg_q16 = cordic_atan(longint'(half) << 16,
                              longint'((err < 0) ? -err : err) * tan_q16);
        if (deg_q16 < 0)
        begin
            deg_q16 = 0;
        end
        // round half up to the angle lsb
        lsbs = int'((deg_q16 + (longint'(1) << (15 - ANGLE_FRAC_BITS)))
                    >>> (16 - ANGLE_FRAC_BITS));
        return (err > 0) ? -lsbs : lsbs;
    endfunction

    // offset from centre, saturated to the half frame, zero inside the dead zone
    function automatic int pixel_offset(input logic [PIX_W-1:0] pos, input int centre,
                                        input int dz, input int half);
        int e;
        e = int'({16'd0, pos}) - centre;
        if (e > half)
        begin
            e = half;
        end
        if (e < -half)
        begin
            e = -half;
        end
        if (e <= dz && e >= -dz)
        begin
            return 0;
        end
        return e;
    endfunction

    // min is checked first: with the two inverted, a value below min gives min, any other gives max
    function automatic int limit_angle(input int v, input int lo, input int hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // next command for one accepted position; moves the held angles
    function automatic cmd_t track_to_cmd(input track_t t);
        cmd_t c;
        int   ex;
        int   ey;
        if (t.pos_x == STOP_CODE && t.pos_y == STOP_CODE)
        begin
            c.status = STATUS_STOP;
            n_stop++;
        end
        else
        begin
            ex = pixel_offset(t.pos_x, int'(ctr_x), int'(dz_pan), HALF_WIDTH);
            ey = pixel_offset(t.pos_y, int'(ctr_y), int'(dz_tilt), HALF_HEIGHT);
            if (ex == 0 && ey == 0)
            begin
                c.status = STATUS_DEAD;
                n_dead++;
            end
            else
            begin
                // an axis with zero error still gets clamped
                cur_pan  = PAN_W'(limit_angle(int'(cur_pan)
                                  + servo_step(ex, HALF_WIDTH, PAN_TAN_Q16),
                                  int'(pan_lo), int'(pan_hi)));
                cur_tilt = TILT_W'(limit_angle(int'(cur_tilt)
                                   + servo_step(ey, HALF_HEIGHT, TILT_TAN_Q16),
                                   int'(tilt_lo), int'(tilt_hi)));
                c.status = STATUS_UPDATED;
                n_moved++;
            end
        end
        c.pan_angle  = cur_pan;
        c.tilt_angle = cur_tilt;
        return c;
    endfunction

    // register write as the block sees it: truncated to the register width
    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CENTER_X: ctr_x   = data[CX_W-1:0];
            REG_CENTER_Y: ctr_y   = data[CY_W-1:0];
            REG_DZ_PAN:   dz_pan  = data[DZP_W-1:0];
            REG_DZ_TILT:  dz_tilt = data[DZT_W-1:0];
            REG_PAN_MIN:  pan_lo  = data[PAN_W-1:0];
            REG_PAN_MAX:  pan_hi  = data[PAN_W-1:0];
            REG_TILT_LO:  tilt_lo = data[TILT_W-1:0];
            REG_TILT_HI:  tilt_hi = data[TILT_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------------

    // half the time, random junk above the register width
    function automatic logic [CFG_DATA_W-1:0] pad_high(input logic [CFG_DATA_W-1:0] v,
                                                       input int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            return v;
        end
        return v | (junk & ~((CFG_DATA_W'(1) << w) - CFG_DATA_W'(1)));
    endfunction

    function automatic tracker_regs_t random_regs();
        tracker_regs_t r;
        int a;
        int b;
        int swap;
        // centre and dead zones mostly in range, sometimes anywhere the width allows
        r.center_x = pad_high(CFG_DATA_W'($urandom_range(0,
                     ($urandom_range(0, 4) == 0) ? 511 : 319)), CX_W);
        r.center_y = pad_high(CFG_DATA_W'($urandom_range(0,
                     ($urandom_range(0, 4) == 0) ? 255 : 239)), CY_W);
        r.dz_pan   = pad_high(CFG_DATA_W'($urandom_range(0,
                     ($urandom_range(0, 3) == 0) ? 255 : 20)), DZP_W);
        r.dz_tilt  = pad_high(CFG_DATA_W'($urandom_range(0,
                     ($urandom_range(0, 3) == 0) ? 127 : 20)), DZT_W);
        // limits usually ordered, one time in ten inverted
        a = $urandom_range(0, 17280);
        b = $urandom_range(0, 17280);
        if ((a > b) != ($urandom_range(0, 9) == 0))
        begin
            swap = a;
            a = b;
            b = swap;
        end
        r.pan_min = pad_high(CFG_DATA_W'(a), PAN_W);
        r.pan_max = pad_high(CFG_DATA_W'(b), PAN_W);
        a = $urandom_range(0, 11520);
        b = $urandom_range(0, 11520);
        if ((a > b) != ($urandom_range(0, 9) == 0))
        begin
            swap = a;
            a = b;
            b = swap;
        end
        r.tilt_lo = pad_high(CFG_DATA_W'(a), TILT_W);
        r.tilt_hi = pad_high(CFG_DATA_W'(b), TILT_W);
        return r;
    endfunction

    // random position: mostly around the frame, with stops, half stops,
    // dead zone hits and full 16-bit noise mixed in
    function automatic track_t next_target();
        track_t t;
        int     kind;
        int     d;
        int     v;
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            t.pos_x = STOP_CODE;
            t.pos_y = STOP_CODE;
        end
        else if (kind < 10)
        begin
            t.pos_x = PIX_W'($urandom_range(0, 520));
            t.pos_y = PIX_W'($urandom_range(0, 400));
            if ($urandom_range(0, 1) == 0)
            begin
                t.pos_x = STOP_CODE;
            end
            else
            begin
                t.pos_y = STOP_CODE;
            end
        end
        else if (kind < 22)
        begin
            d = int'(dz_pan);
            v = int'(ctr_x) + int'($urandom_range(0, 2 * d)) - d;
            t.pos_x = PIX_W'((v < 0) ? 0 : v);
            d = int'(dz_tilt);
            v = int'(ctr_y) + int'($urandom_range(0, 2 * d)) - d;
            t.pos_y = PIX_W'((v < 0) ? 0 : v);
        end
        else if (kind < 32)
        begin
            t.pos_x = PIX_W'($urandom);
            t.pos_y = PIX_W'($urandom);
        end
        else
        begin
            t.pos_x = PIX_W'($urandom_range(0, 520));
            t.pos_y = PIX_W'($urandom_range(0, 400));
        end
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------

    // one track transfer; valid stays up after acceptance so back-to-back
    // items never see valid dropped and raised in the same step
    task automatic send_target(input track_t t);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            track_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        track_valid <= 1'b1;
        track       <= t;
        @(posedge clk);
        while (!track_ready)
        begin
            @(posedge clk);
        end
        pending_cmds.push_back(track_to_cmd(t));
        n_sent++;
    endtask

    // drop valid and let every owed command drain, plus the pipeline depth
    task automatic settle();
        track_valid <= 1'b0;
        while (pending_cmds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        store_reg(idx, data);
    endtask

    // registers only change with the block empty
    task automatic apply_settings(input tracker_regs_t r);
        settle();
        write_reg(REG_CENTER_X, r.center_x);
        write_reg(REG_CENTER_Y, r.center_y);
        write_reg(REG_DZ_PAN,   r.dz_pan);
        write_reg(REG_DZ_TILT,  r.dz_tilt);
        write_reg(REG_PAN_MIN,  r.pan_min);
        write_reg(REG_PAN_MAX,  r.pan_max);
        write_reg(REG_TILT_LO,  r.tilt_lo);
        write_reg(REG_TILT_HI,  r.tilt_hi);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // cmd receiver: random stall before each transfer, or one long hold
    // when a test asks for it, counted here
    initial
    begin
        int stall;
        forever
        begin
            if (hold_off_request > 0)
            begin
                stall = hold_off_request;
                hold_off_request = 0;
                n_long_holds++;
            end
            else
            begin
                stall = $urandom_range(0, stall_max);
            end
            if (stall > 0)
            begin
                cmd_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cmd_ready <= 1'b1;
            @(posedge clk);
            while (!cmd_valid)
            begin
                @(posedge clk);
            end
        end
    end

    // compare every cmd transfer with the oldest owed command
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && cmd_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: cmd transfer with nothing owed: pan %0d tilt %0d status %0d",
                         $time, cmd.pan_angle, cmd.tilt_angle, cmd.status);
                n_errors++;
            end
            else
            begin
                oldest_cmd = pending_cmds.pop_front();
                n_checked++;
                if (cmd.pan_angle !== oldest_cmd.pan_angle)
                begin
                    $display("%0t: pan_angle mismatch: expected %0d actual %0d",
                             $time, oldest_cmd.pan_angle, cmd.pan_angle);
                    n_errors++;
                end
                if (cmd.tilt_angle !== oldest_cmd.tilt_angle)
                begin
                    $display("%0t: tilt_angle mismatch: expected %0d actual %0d",
                             $time, oldest_cmd.tilt_angle, cmd.tilt_angle);
                    n_errors++;
                end
                if (cmd.status !== oldest_cmd.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, oldest_cmd.status, cmd.status);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: too long without any transfer means the block is hung
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((track_valid && track_ready) || (cmd_valid && cmd_ready) || cfg_wr_en)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles, %0d commands still owed",
                 $time, QUIET_LIMIT, pending_cmds.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: centre, dead zone edges, stop and half stop codes,
    // saturation in both directions, alternating bit patterns
    task automatic test_directed_cases();
        logic [31:0] spots [22] = '{
            {16'd160, 16'd120},            // both errors zero
            {STOP_CODE, STOP_CODE},        // stop
            {16'd0, 16'd0},                // full negative saturation
            {16'd319, 16'd239},
            {STOP_CODE, 16'd120},          // lone 65535 is a position
            {16'd160, STOP_CODE},
            {STOP_CODE, 16'd0},
            {16'd165, 16'd125},            // on the dead zone edge
            {16'd155, 16'd115},
            {16'd166, 16'd120},            // one past the edge, tilt zero
            {16'd154, 16'd120},
            {16'd160, 16'd126},            // pan zero, still clamped
            {16'd160, 16'd114},
            {16'd0, 16'd120},
            {16'd160, 16'd239},
            {16'hAAAA, 16'h5555},
            {16'h5555, 16'hAAAA},
            {STOP_CODE, 16'hFFFE},         // near miss on the stop code
            {16'hFFFE, STOP_CODE},
            {16'd0, 16'd0},
            {16'd0, 16'd0},
            {STOP_CODE, STOP_CODE}
        };
        gap_max   = 6;
        stall_max = 6;
        foreach (spots[k])
        begin
            send_target(track_t'(spots[k]));
        end
    endtask

    // limit corners: inverted min/max, full register width, pinned limits,
    // then back to reset values
    task automatic test_limit_extremes();
        tracker_regs_t corners [4] = '{
            '{15'd160, 15'd120, 15'd0, 15'd0, 15'd17280, 15'd0, 15'd11520, 15'd0},
            '{15'd511, 15'd255, 15'd255, 15'd127, 15'd0, 15'h7FFF, 15'd0, 15'h3FFF},
            '{15'd0, 15'd0, 15'd160, 15'd120, 15'd17280, 15'd17280, 15'd0, 15'd0},
            '{CFG_DATA_W'(CENTER_X_RST), CFG_DATA_W'(CENTER_Y_RST),
              CFG_DATA_W'(DZ_PAN_RST), CFG_DATA_W'(DZ_TILT_RST),
              CFG_DATA_W'(PAN_MIN_RST), CFG_DATA_W'(PAN_MAX_RST),
              CFG_DATA_W'(TILT_LO_RST), CFG_DATA_W'(TILT_HI_RST)}
        };
        foreach (corners[c])
        begin
            apply_settings(corners[c]);
            for (int n = 0; n < 10; n++)
            begin
                send_target(next_target());
            end
        end
    endtask

    // random register settings, traffic switching at random between idle-heavy
    // stretches and full-rate stretches on each side
    task automatic test_random_traffic();
        for (int p = 0; p < 6; p++)
        begin
            apply_settings(random_regs());
            for (int n = 0; n < 130; n++)
            begin
                if (n % 40 == 0)
                begin
                    gap_max   = ($urandom_range(0, 1) == 0) ? 0 : 6;
                    stall_max = ($urandom_range(0, 1) == 0) ? 0 : 6;
                end
                send_target(next_target());
            end
        end
    endtask

    // receiver holds off while the sender keeps offering at full rate,
    // so the block fills and has to stall its input
    task automatic test_output_stall();
        settle();
        gap_max   = 0;
        stall_max = 6;
        hold_off_request = LONG_HOLD;
        for (int n = 0; n < 30; n++)
        begin
            send_target(next_target());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_limit_extremes();
        test_random_traffic();
        test_output_stall();
        settle();

        $display("%0d positions sent, %0d commands checked: %0d moved, %0d dead zone, %0d stop",
                 n_sent, n_checked, n_moved, n_dead, n_stop);
        $display("%0d register settings incl. inverted and full-width limits,",
                 n_settings);
        $display("%0d long hold(s), %0d mismatches", n_long_holds, n_errors);
        if (n_errors == 0 && pending_cmds.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ptpe_pkg.sv
rtl/ptpe_err.sv
rtl/ptpe_clamp.sv
rtl/pan_tilt_pixel_error_tracker.sv
rtl/ptpe_checker.sv
dv/tb_top.sv
